[rtl/common_prime_divisor_pair_counter_macros.svh]
// ----------------------------------------------------------------------------
// common prime divisor pair counter assertion macros
// shared concurrent assertion forms for the rtl modules
// ----------------------------------------------------------------------------
`ifndef COMMON_PRIME_DIVISOR_PAIR_COUNTER_MACROS_SVH
`define COMMON_PRIME_DIVISOR_PAIR_COUNTER_MACROS_SVH

// same-cycle implication
`define CPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpd assertion failed");

// next-cycle implication
`define CPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpd assertion failed");

`endif

[rtl/cpd_pkg.sv]
// ----------------------------------------------------------------------------
// cpd_pkg
// shared widths, state and command types of the prime divisor pair counter
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

    localparam int OP_W   = 31;
    localparam int CNT_W  = 16;
    localparam int TWOS_W = $clog2(OP_W + 1);
    localparam int DCNT_W = $clog2(OP_W + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_GCD_D,
        S_TEST_D,
        S_DIV,
        S_TEST_Q,
        S_GCD_T,
        S_TEST_T,
        S_DONE
    } state_t;

    typedef enum logic {
        GCD_AB,
        GCD_QD
    } gcd_src_t;

    typedef enum logic [1:0] {
        DIV_A_D,
        DIV_B_D,
        DIV_Q_G
    } div_src_t;

    typedef struct packed {
        logic     load;
        logic     gcd_start;
        gcd_src_t gcd_src;
        logic     gcd_step;
        logic     save_d;
        logic     div_start;
        div_src_t div_src;
        logic     div_step;
        logic     save_q;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic gcd_done;
        logic g_one;
        logic d_one;
        logic ab_equal;
        logic q_one;
        logic div_done;
    } stat_t;

endpackage

`default_nettype wire

[rtl/cpd_datapath.sv]
// ----------------------------------------------------------------------------
// cpd_datapath
// operand registers, one-step binary gcd unit and bit-serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_datapath
(
    input  wire logic                     clk,
    input  wire logic [cpd_pkg::OP_W-1:0] operand_a,
    input  wire logic [cpd_pkg::OP_W-1:0] operand_b,
    input  wire cpd_pkg::cmd_t            cmd,
    output cpd_pkg::stat_t                stat
);

    logic [cpd_pkg::OP_W-1:0]   a_reg, b_reg, d_reg, q_reg;
    logic [cpd_pkg::OP_W-1:0]   x_reg, y_reg, x_next, y_next;
    logic [cpd_pkg::TWOS_W-1:0] twos_reg, twos_next;
    logic [cpd_pkg::OP_W-1:0]   num_reg, rem_reg, den_reg;
    logic [cpd_pkg::DCNT_W-1:0] dcnt_reg;
    logic [cpd_pkg::OP_W-1:0]   gcd_val;
    logic [cpd_pkg::OP_W:0]     rem_sh, rem_diff;
    logic                       rem_ge;

    assign gcd_val = x_reg << twos_reg;

    // one stein step
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        twos_next = twos_reg;
        priority if (!x_reg[0] && !y_reg[0])
        begin
            x_next    = x_reg >> 1;
            y_next    = y_reg >> 1;
            twos_next = twos_reg + 1'b1;
        end
        else if (!x_reg[0])
        begin
            x_next = x_reg >> 1;
        end
        else if (y_reg == '0)
        begin
            y_next = y_reg;
        end
        else if (!y_reg[0])
        begin
            y_next = y_reg >> 1;
        end
        else if (x_reg > y_reg)
        begin
            x_next = y_reg;
            y_next = x_reg - y_reg;
        end
        else
        begin
            y_next = y_reg - x_reg;
        end
    end

    // restoring division step
    assign rem_sh   = {rem_reg, num_reg[cpd_pkg::OP_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (cmd.gcd_start)
        begin
            unique case (cmd.gcd_src)
                cpd_pkg::GCD_AB:
                begin
                    x_reg <= a_reg;
                    y_reg <= b_reg;
                end
                cpd_pkg::GCD_QD:
                begin
                    x_reg <= q_reg;
                    y_reg <= d_reg;
                end
                default:
                begin
                    x_reg <= a_reg;
                    y_reg <= b_reg;
                end
            endcase
            twos_reg <= '0;
        end
        else if (cmd.gcd_step)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            twos_reg <= twos_next;
        end
        if (cmd.save_d)
        begin
            d_reg <= gcd_val;
        end
        if (cmd.div_start)
        begin
            unique case (cmd.div_src)
                cpd_pkg::DIV_A_D:
                begin
                    num_reg <= a_reg;
                    den_reg <= d_reg;
                end
                cpd_pkg::DIV_B_D:
                begin
                    num_reg <= b_reg;
                    den_reg <= d_reg;
                end
                default:
                begin
                    num_reg <= q_reg;
                    den_reg <= gcd_val;
                end
            endcase
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_diff[cpd_pkg::OP_W-1:0] : rem_sh[cpd_pkg::OP_W-1:0];
            num_reg  <= {num_reg[cpd_pkg::OP_W-2:0], rem_ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.save_q)
        begin
            q_reg <= num_reg;
        end
    end

    assign stat.bad      = (a_reg == '0) || (b_reg == '0);
    assign stat.gcd_done = x_reg[0] && (y_reg == '0);
    assign stat.g_one    = gcd_val == cpd_pkg::OP_W'(1);
    assign stat.d_one    = d_reg == cpd_pkg::OP_W'(1);
    assign stat.ab_equal = a_reg == b_reg;
    assign stat.q_one    = q_reg == cpd_pkg::OP_W'(1);
    assign stat.div_done = dcnt_reg == cpd_pkg::DCNT_W'(cpd_pkg::OP_W);

endmodule

`default_nettype wire

[rtl/cpd_ctrl.sv]
// ----------------------------------------------------------------------------
// cpd_ctrl
// sequencer for gcd, quotient reduction and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

`include "common_prime_divisor_pair_counter_macros.svh"

module cpd_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic           out_free,
    input  wire cpd_pkg::stat_t stat,
    output cpd_pkg::cmd_t       cmd,
    output logic                idle,
    output logic                finish,
    output logic                same,
    output logic                bad
);

    cpd_pkg::state_t state_reg, state_next;
    logic sel_b_reg, sel_b_next;
    logic same_reg, same_next;
    logic bad_reg, bad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpd_pkg::S_IDLE;
            sel_b_reg <= 1'b0;
            same_reg  <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_b_reg <= sel_b_next;
            same_reg  <= same_next;
            bad_reg   <= bad_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        sel_b_next = sel_b_reg;
        same_next  = same_reg;
        bad_next   = bad_reg;
        unique case (state_reg)
            cpd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cpd_pkg::S_CHECK;
                end
            end
            cpd_pkg::S_CHECK:
            begin
                sel_b_next = 1'b0;
                same_next  = 1'b0;
                bad_next   = stat.bad;
                state_next = stat.bad ? cpd_pkg::S_DONE : cpd_pkg::S_GCD_D;
            end
            cpd_pkg::S_GCD_D:
            begin
                if (stat.gcd_done)
                begin
                    state_next = cpd_pkg::S_TEST_D;
                end
            end
            cpd_pkg::S_TEST_D:
            begin
                state_next = (stat.d_one && !stat.ab_equal) ? cpd_pkg::S_DONE : cpd_pkg::S_DIV;
            end
            cpd_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = cpd_pkg::S_TEST_Q;
                end
            end
            cpd_pkg::S_TEST_Q:
            begin
                if (!stat.q_one)
                begin
                    state_next = cpd_pkg::S_GCD_T;
                end
                else if (!sel_b_reg)
                begin
                    sel_b_next = 1'b1;
                    state_next = cpd_pkg::S_DIV;
                end
                else
                begin
                    same_next  = 1'b1;
                    state_next = cpd_pkg::S_DONE;
                end
            end
            cpd_pkg::S_GCD_T:
            begin
                if (stat.gcd_done)
                begin
                    state_next = cpd_pkg::S_TEST_T;
                end
            end
            cpd_pkg::S_TEST_T:
            begin
                state_next = stat.g_one ? cpd_pkg::S_DONE : cpd_pkg::S_DIV;
            end
            cpd_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = cpd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cpd_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd         = '0;
        cmd.gcd_src = cpd_pkg::GCD_AB;
        cmd.div_src = cpd_pkg::DIV_A_D;
        idle        = 1'b0;
        finish      = 1'b0;
        unique case (state_reg)
            cpd_pkg::S_IDLE:
            begin
                idle     = 1'b1;
                cmd.load = accept;
            end
            cpd_pkg::S_CHECK:
            begin
                cmd.gcd_start = 1'b1;
            end
            cpd_pkg::S_GCD_D:
            begin
                cmd.gcd_step = !stat.gcd_done;
                cmd.save_d   = stat.gcd_done;
            end
            cpd_pkg::S_TEST_D:
            begin
                cmd.div_start = 1'b1;
            end
            cpd_pkg::S_DIV:
            begin
                cmd.div_step = !stat.div_done;
                cmd.save_q   = stat.div_done;
            end
            cpd_pkg::S_TEST_Q:
            begin
                cmd.gcd_start = !stat.q_one;
                cmd.gcd_src   = cpd_pkg::GCD_QD;
                cmd.div_start = stat.q_one && !sel_b_reg;
                cmd.div_src   = cpd_pkg::DIV_B_D;
            end
            cpd_pkg::S_GCD_T:
            begin
                cmd.gcd_step = !stat.gcd_done;
            end
            cpd_pkg::S_TEST_T:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = cpd_pkg::DIV_Q_G;
            end
            cpd_pkg::S_DONE:
            begin
                finish = out_free;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    assign same = same_reg;
    assign bad  = bad_reg;

    `CPD_ASSERT_NOW(a_no_same_on_bad, clk, rst_n, finish && bad_reg, !same_reg)
    `CPD_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept && idle, state_reg == cpd_pkg::S_CHECK)
    `CPD_ASSERT_NOW(a_div_cmd_excl, clk, rst_n, cmd.div_start, !cmd.div_step && !cmd.gcd_step)

endmodule

`default_nettype wire

[rtl/common_prime_divisor_pair_counter.sv]
// ----------------------------------------------------------------------------
// common_prime_divisor_pair_counter
// same-prime-set test of integer pairs with a saturating match count
// ----------------------------------------------------------------------------
// one pair is worked at a time: item_stall is high from acceptance until the
// result is handed to the output register. the time a pair takes depends on
// its data, through the single shared stein gcd unit (one shift or subtract a
// cycle, used for the first gcd of the two operands and for the later ones,
// whose operands multiply to at most one operand) and the bit-serial
// restoring divider. a zero operand goes from the check state straight to the
// done state with bad_operand set. the output register lets the next pair
// start while a result is still waiting on result_stall.
`default_nettype none

`include "common_prime_divisor_pair_counter_macros.svh"

module common_prime_divisor_pair_counter
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire logic [cpd_pkg::OP_W-1:0]  operand_a,
    input  wire logic [cpd_pkg::OP_W-1:0]  operand_b,
    input  wire logic                      last_pair,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output logic                           same_primes,
    output logic [cpd_pkg::CNT_W-1:0]      match_count,
    output logic                           bad_operand,
    output logic                           set_done
);

    cpd_pkg::cmd_t  cmd;
    cpd_pkg::stat_t stat;
    logic idle, finish, same, bad, accept, out_free;

    // running count and the pair's set-end flag
    logic [cpd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      last_reg;

    // output transaction register
    logic                      out_valid_reg;
    logic                      same_reg, bad_reg, done_reg;
    logic [cpd_pkg::CNT_W-1:0] shown_reg;

    assign item_stall = !idle;
    assign accept     = item_valid && idle;
    assign out_free   = !out_valid_reg || !result_stall;

    cpd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle),
        .finish   (finish),
        .same     (same),
        .bad      (bad)
    );

    cpd_datapath u_datapath
    (
        .clk       (clk),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cmd       (cmd),
        .stat      (stat)
    );

    // saturating increment on a match
    assign cnt_next = (same && (cnt_reg != {cpd_pkg::CNT_W{1'b1}})) ? cnt_reg + 1'b1 : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                cnt_reg       <= last_reg ? '0 : cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_pair;
        end
        if (finish)
        begin
            same_reg  <= same;
            bad_reg   <= bad;
            done_reg  <= last_reg;
            shown_reg <= cnt_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign same_primes  = same_reg;
    assign bad_operand  = bad_reg;
    assign set_done     = done_reg;
    assign match_count  = shown_reg;

    `CPD_ASSERT_NOW(a_no_overwrite, clk, rst_n, finish, !(out_valid_reg && result_stall))
    `CPD_ASSERT_NEXT(a_stall_after_accept, clk, rst_n, accept, item_stall)
    `CPD_ASSERT_NEXT(a_clear_after_last, clk, rst_n, finish && last_reg, cnt_reg == '0)

endmodule

`default_nettype wire

[verif/common_prime_divisor_pair_counter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// common prime divisor pair counter testbench
// drives integer pairs through the valid/stall handshake, predicts the
// same-prime-set flag and the saturating per-set match count, and checks
// every result transaction against the queue of predicted results
// ----------------------------------------------------------------------------
`default_nettype none

module common_prime_divisor_pair_counter_tb;

    localparam int          MAX_WAIT = 20000;
    localparam logic [15:0] CNT_MAX  = 16'hFFFF;

    // one predicted result transaction
    typedef struct {
        logic        same;
        logic [15:0] count;
        logic        bad;
        logic        done;
    } verdict_t;

    logic                       clk;
    logic                       rst_n;
    logic                       item_valid;
    logic                       item_stall;
    logic [cpd_pkg::OP_W-1:0]   operand_a;
    logic [cpd_pkg::OP_W-1:0]   operand_b;
    logic                       last_pair;
    logic                       result_valid;
    logic                       result_stall;
    logic                       same_primes;
    logic [cpd_pkg::CNT_W-1:0]  match_count;
    logic                       bad_operand;
    logic                       set_done;

    verdict_t    verdict_q[$];
    logic [15:0] running_matches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          pairs_sent;
    int          results_seen;
    int          matches_seen;
    int          bad_seen;

    common_prime_divisor_pair_counter u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .last_pair    (last_pair),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .same_primes  (same_primes),
        .match_count  (match_count),
        .bad_operand  (bad_operand),
        .set_done     (set_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs on a transaction
    initial
    begin
        #400ms;
        $display("status: fail");
        $finish;
    end

    // stein gcd, both arguments nonzero
    function automatic logic [63:0] stein_gcd(logic [63:0] x, logic [63:0] y);
        int          twos;
        logic [63:0] t;
        twos = 0;
        while (((x | y) & 64'd1) == 64'd0)
        begin
            x = x >> 1;
            y = y >> 1;
            twos++;
        end
        while (x[0] == 1'b0)
            x = x >> 1;
        while (y != 64'd0)
        begin
            while (y[0] == 1'b0)
                y = y >> 1;
            if (x > y)
            begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x << twos;
    endfunction

    // true when every prime of q also divides d
    function automatic bit primes_within(logic [63:0] q, logic [63:0] d);
        logic [63:0] g;
        while (q != 64'd1)
        begin
            g = stein_gcd(q, d);
            if (g == 64'd1)
                return 1'b0;
            q = q / g;
        end
        return 1'b1;
    endfunction

    // predict one pair's result and advance the running count
    function automatic verdict_t predict_pair(logic [cpd_pkg::OP_W-1:0] a,
                                              logic [cpd_pkg::OP_W-1:0] b,
                                              logic last);
        verdict_t    v;
        logic [63:0] d;
        v.same = 1'b0;
        v.bad  = 1'b0;
        v.done = last;
        if (a == '0 || b == '0)
            v.bad = 1'b1;
        else
        begin
            d = stein_gcd(64'(a), 64'(b));
            // coprime distinct pairs never match
            if (!(d == 64'd1 && a != b))
                v.same = primes_within(64'(a) / d, d) && primes_within(64'(b) / d, d);
        end
        if (v.same && running_matches < CNT_MAX)
            running_matches++;
        v.count = running_matches;
        if (last)
            running_matches = '0;
        return v;
    endfunction

    // send one pair; the payload holds steady while stalled, valid stays up
    // after acceptance until the next falling edge decides what comes next
    task automatic send_pair(logic [cpd_pkg::OP_W-1:0] a, logic [cpd_pkg::OP_W-1:0] b,
                             logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        verdict_q.push_back(predict_pair(a, b, last));
        item_valid <= 1'b1;
        operand_a  <= a;
        operand_b  <= b;
        last_pair  <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pairs_sent++;
        @(negedge clk);
    endtask

    // wait until every predicted result has come back
    task automatic drain_results();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        while (verdict_q.size() != 0 && waited < MAX_WAIT * 4)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
    endtask

    // random stall on the result side, changed at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker at the rising edge
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (verdict_q.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result same=%0b count=%0d bad=%0b done=%0b",
                         $time, same_primes, match_count, bad_operand, set_done);
            end
            else
            begin
                v = verdict_q.pop_front();
                if (same_primes !== v.same)
                begin
                    error_count++;
                    $display("%0t same_primes expected %0b actual %0b",
                             $time, v.same, same_primes);
                end
                if (match_count !== v.count[cpd_pkg::CNT_W-1:0])
                begin
                    error_count++;
                    $display("%0t match_count expected %0d actual %0d",
                             $time, v.count, match_count);
                end
                if (bad_operand !== v.bad)
                begin
                    error_count++;
                    $display("%0t bad_operand expected %0b actual %0b",
                             $time, v.bad, bad_operand);
                end
                if (set_done !== v.done)
                begin
                    error_count++;
                    $display("%0t set_done expected %0b actual %0b",
                             $time, v.done, set_done);
                end
                if (v.same)
                    matches_seen++;
                if (v.bad)
                    bad_seen++;
            end
        end
    end

    // random operand built from a few small primes, so matches are common
    function automatic logic [cpd_pkg::OP_W-1:0] smooth_operand(int unsigned pool);
        logic [63:0] n;
        int unsigned primes[6];
        int unsigned p;
        primes = '{2, 3, 5, 7, 11, 13};
        n = 64'd1;
        repeat ($urandom_range(8, 1))
        begin
            p = primes[$urandom_range(pool - 1)];
            if (n * p < 64'h8000_0000)
                n = n * p;
        end
        return n[cpd_pkg::OP_W-1:0];
    endfunction

    // extremes, zero operands, ones, coprime pairs, wide values
    task automatic test_directed();
        send_pair('0, 31'd5, 1'b0);
        send_pair(31'd7, '0, 1'b0);
        send_pair('0, '0, 1'b0);
        send_pair(31'd1, 31'd1, 1'b0);
        send_pair(31'd1, 31'd2, 1'b0);
        send_pair(31'd9, 31'd10, 1'b0);
        send_pair(31'd12, 31'd18, 1'b0);
        send_pair(31'd75, 31'd15, 1'b0);
        send_pair(31'd10, 31'd30, 1'b0);
        send_pair(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_pair(31'h7FFF_FFFF, 31'd1, 1'b0);
        send_pair(31'h4000_0000, 31'd2, 1'b0);
        send_pair(31'h4000_0000, 31'h7FFF_FFFE, 1'b0);
        send_pair(31'd2147483629, 31'd2147483629, 1'b0);
        send_pair(31'h1555_5555, 31'h2AAA_AAAA, 1'b1);
        send_pair(31'd17, 31'd289, 1'b1);
        send_pair(31'd6, 31'd35, 1'b1);
    endtask

    // random pairs: mostly smooth numbers, some fully random bit patterns
    task automatic test_random(int n);
        logic [cpd_pkg::OP_W-1:0] a;
        logic [cpd_pkg::OP_W-1:0] b;
        repeat (n)
        begin
            case ($urandom_range(9))
                0:
                begin
                    a = cpd_pkg::OP_W'($urandom);
                    b = cpd_pkg::OP_W'($urandom);
                end
                1:
                begin
                    a = cpd_pkg::OP_W'($urandom);
                    b = a;
                end
                2:
                begin
                    a = cpd_pkg::OP_W'($urandom_range(3));
                    b = cpd_pkg::OP_W'($urandom_range(3));
                end
                default:
                begin
                    a = smooth_operand(4);
                    b = smooth_operand(4);
                end
            endcase
            send_pair(a, b, $urandom_range(11) == 0);
        end
    endtask

    // hold the sender until the block has fully emptied
    task automatic test_pause_until_drained();
        send_pair(31'd36, 31'd48, 1'b0);
        send_pair(31'd35, 31'd49, 1'b0);
        drain_results();
        send_pair(31'd14, 31'd28, 1'b1);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        operand_a     = '0;
        operand_b     = '0;
        last_pair     = 1'b0;
        result_stall  = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 62;
        error_count   = 0;
        pairs_sent    = 0;
        results_seen  = 0;
        matches_seen  = 0;
        bad_seen      = 0;
        running_matches = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles lightly, receiver heavily
        test_directed();
        test_random(100);
        test_pause_until_drained();

        // then the other way round
        send_idle_pct = 62;
        recv_idle_pct = 18;
        test_random(100);

        // then full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(100);

        drain_results();
        if (verdict_q.size() != 0)
        begin
            error_count++;
            $display("%0t %0d predicted results never arrived", $time, verdict_q.size());
        end
        $display("covered %0d pairs, %0d results, %0d matches, %0d zero-operand pairs",
                 pairs_sent, results_seen, matches_seen, bad_seen);
        $display("including set ends, a full drain and three handshake idle mixes");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[common_prime_divisor_pair_counter.f]
+incdir+rtl
rtl/cpd_pkg.sv
rtl/cpd_datapath.sv
rtl/cpd_ctrl.sv
rtl/common_prime_divisor_pair_counter.sv
verif/common_prime_divisor_pair_counter_tb.sv
